[sv/nsp_pkg.sv]
// Shared types and command codes for the nested section profiler.
package nsp_pkg;
	typedef enum logic [2:0] {
		CMD_ENTER      = 3'd0,
		CMD_EXIT       = 3'd1,
		CMD_FRAME_BEG  = 3'd2,
		CMD_FRAME_END  = 3'd3,
		CMD_UPLOAD     = 3'd4,
		CMD_OVERLAY    = 3'd5,
		CMD_READ_WORST = 3'd6,
		CMD_READ_RUN   = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_RANK,
		ST_RUN_RD,
		ST_DONE
	} state_t;

	// Control broadcast from the sequencer to every worst-table cell.
	typedef struct packed {
		logic        insert;
		logic [31:0] frame;
		logic [31:0] ticks;
	} wcell_ctl_t;

	localparam int RUN_TOTAL_COUNT = 5;
endpackage

[sv/nested_section_profiler_topk.sv]
// Top level of the nested section profiler with a ranked worst-frame table.
// One event word is taken at a time and answered with one result word. Enter,
// exit, frame begin, counter events, read_worst and a refused frame end answer
// from the done state; read_run registers its pick in a run-read state first. A
// closing frame end passes fold and rank states: the section accumulators form
// a ring of cells that rotates once, one section a cycle, each cell folding its
// own section into its 64-bit run total on the first step; the worst table is
// a row of cells that ranks and shifts in the rank state. Input stall is high
// while an event is in flight and while a result waits to be taken.
module nested_section_profiler_topk #(
	parameter int STACK_DEPTH   = 8,
	parameter int WORST_ENTRIES = 16,
	parameter int SECTION_COUNT = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] timestamp,
	input  logic [4:0]  section,
	input  logic [31:0] start_token,
	input  logic [31:0] byte_count,
	input  logic        first_draw,
	input  logic [4:0]  index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [31:0] token_out,
	output logic [31:0] frame_number,
	output logic [4:0]  rank,
	output logic [63:0] read_value
);
	import nsp_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SPI = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int FCW = $clog2(SECTION_COUNT + 1);
	localparam int WCW = $clog2(WORST_ENTRIES + 1);

	state_t state_q, state_nx;
	logic enable_q;
	logic [SPW-1:0] level_q;
	logic [4:0] stk_sec_q [STACK_DEPTH];
	logic [31:0] fcnt_q [4];
	logic frame_open_q;
	logic [31:0] fstart_q, fclosed_q;
	logic [63:0] rtot_q [RUN_TOTAL_COUNT];
	logic [FCW-1:0] fold_cnt_q;
	logic [31:0] total_q;
	logic [WCW-1:0] rank_pos;

	// latched event
	cmd_t cmd_q;
	logic [31:0] ts_q, tok_q, bytes_q;
	logic [4:0] sec_q, idx_q;
	logic first_q;

	logic res_acc_q;
	logic [31:0] res_tok_q, res_fnum_q;
	logic [4:0] res_rank_q;
	logic [63:0] res_val_q;
	logic res_valid_q;

	logic take;
	assign take = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || res_valid_q;
	assign cfg_ready = 1'b1;

	// ---------- fold ring ----------
	logic [31:0] ft [SECTION_COUNT];
	logic [63:0] rt [SECTION_COUNT];
	logic fold_shift, fclear, sec_ok;
	assign fold_shift = (state_q == ST_FOLD);
	assign sec_ok = ({1'b0, sec_q} < 6'(SECTION_COUNT));

	logic stk_top_match;
	logic [SPI-1:0] top_idx;
	assign top_idx = SPI'(level_q - SPW'(1));
	assign stk_top_match = (level_q != '0) && (stk_sec_q[top_idx] == sec_q);

	logic exit_ok;
	assign exit_ok = enable_q && (tok_q != '0) && sec_ok && stk_top_match;
	assign fclear = (state_q == ST_DONE) && cmd_q == CMD_FRAME_BEG && enable_q;

	for (genvar g = 0; g < SECTION_COUNT; g++) begin : g_fold
		nsp_fold_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.clear(fclear),
			.add((state_q == ST_DONE) && cmd_q == CMD_EXIT && exit_ok
				&& sec_q == 5'(g)),
			.add_value(ts_q - tok_q),
			.shift(fold_shift),
			.fold(fold_cnt_q == '0),
			.shift_in(ft[(g + 1) % SECTION_COUNT]),
			.frame_ticks(ft[g]),
			.run_ticks(rt[g])
		);
	end

	// ---------- worst table ----------
	wcell_ctl_t wctl;
	logic wv [WORST_ENTRIES+1];
	logic wtk [WORST_ENTRIES+1];
	logic [31:0] wf [WORST_ENTRIES+1];
	logic [31:0] wt [WORST_ENTRIES+1];
	assign wv[0] = 1'b0;
	assign wtk[0] = 1'b0;
	assign wf[0] = '0;
	assign wt[0] = '0;
	assign wctl.insert = (state_q == ST_RANK);
	assign wctl.frame  = fclosed_q;
	assign wctl.ticks  = total_q;

	for (genvar g = 0; g < WORST_ENTRIES; g++) begin : g_worst
		nsp_worst_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(wctl),
			.up_valid(wv[g]), .up_takes(wtk[g]), .up_frame(wf[g]), .up_ticks(wt[g]),
			.valid(wv[g+1]), .takes(wtk[g+1]), .frame(wf[g+1]), .ticks(wt[g+1])
		);
	end

	// rank = number of cells that do not take the frame
	always_comb begin
		rank_pos = WCW'(WORST_ENTRIES);
		for (int i = WORST_ENTRIES - 1; i >= 0; i--) begin
			if (wtk[i+1] && !wtk[i]) rank_pos = WCW'(i);
		end
	end

	logic [4:0] rank_s2;

	// read_run selection, registered once
	logic [63:0] run_sel;
	logic run_ok;
	logic [63:0] runsel_s2;
	logic runok_s2;

	always_comb begin
		run_ok  = 1'b0;
		run_sel = '0;
		for (int i = 0; i < SECTION_COUNT; i++)
			if (idx_q == 5'(i)) begin
				run_ok  = 1'b1;
				run_sel = rt[i];
			end
		for (int i = 0; i < RUN_TOTAL_COUNT; i++)
			if ({1'b0, idx_q} == 6'(SECTION_COUNT + i)) begin
				run_ok  = 1'b1;
				run_sel = rtot_q[i];
			end
	end

	// ---------- sequencer ----------
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (take) begin
				if (command == CMD_FRAME_END && enable_q && frame_open_q) state_nx = ST_FOLD;
				else if (command == CMD_READ_RUN) state_nx = ST_RUN_RD;
				else state_nx = ST_DONE;
			end
			ST_FOLD: if (fold_cnt_q == FCW'(SECTION_COUNT - 1)) state_nx = ST_RANK;
			ST_RANK: state_nx = ST_DONE;
			ST_RUN_RD: state_nx = ST_DONE;
			ST_DONE: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	logic fe_ok;
	assign fe_ok = enable_q && frame_open_q;

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q   <= cmd_t'(command);
			ts_q    <= timestamp;
			tok_q   <= start_token;
			bytes_q <= byte_count;
			sec_q   <= section;
			idx_q   <= index;
			first_q <= first_draw;
		end
		if (state_q == ST_RANK) rank_s2 <= 5'(rank_pos);
		if (state_q == ST_RUN_RD) begin
			runok_s2  <= run_ok;
			runsel_s2 <= run_sel;
		end
	end

	logic enter_ok;
	assign enter_ok = enable_q && (level_q < SPW'(STACK_DEPTH)) && sec_ok;

	logic [31:0] rd_frame, rd_ticks;
	always_comb begin
		rd_frame = '0;
		rd_ticks = '0;
		for (int i = 0; i < WORST_ENTRIES; i++)
			if (idx_q == 5'(i)) begin
				rd_frame = wf[i+1];
				rd_ticks = wt[i+1];
			end
	end
	logic rd_valid;
	always_comb begin
		rd_valid = 1'b0;
		for (int i = 0; i < WORST_ENTRIES; i++)
			if (idx_q == 5'(i)) rd_valid = wv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			enable_q     <= 1'b0;
			level_q      <= '0;
			frame_open_q <= 1'b0;
			fstart_q     <= '0;
			fclosed_q    <= '0;
			fold_cnt_q   <= '0;
			total_q      <= '0;
			res_valid_q  <= 1'b0;
			for (int i = 0; i < 4; i++) fcnt_q[i] <= '0;
			for (int i = 0; i < RUN_TOTAL_COUNT; i++) rtot_q[i] <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) enable_q <= cfg_data;
			if (res_valid_q && !out_stall) res_valid_q <= 1'b0;
			if (state_q == ST_IDLE && take && command == CMD_FRAME_END) begin
				fold_cnt_q <= '0;
			end
			if (state_q == ST_FOLD) fold_cnt_q <= fold_cnt_q + FCW'(1);
			if (state_q == ST_IDLE && state_nx == ST_FOLD && enable_q && frame_open_q) begin
				// total and run totals are ready before ranking
				total_q   <= timestamp - fstart_q;
				fclosed_q <= fclosed_q + 32'd1;
				frame_open_q <= 1'b0;
				rtot_q[0] <= rtot_q[0] + {32'd0, timestamp - fstart_q};
				for (int i = 0; i < 4; i++) rtot_q[i+1] <= rtot_q[i+1] + {32'd0, fcnt_q[i]};
			end
			if (state_q == ST_DONE) begin
				res_valid_q <= 1'b1;
				res_acc_q <= 1'b0;
				res_tok_q <= '0;
				res_fnum_q <= '0;
				res_rank_q <= '0;
				res_val_q <= '0;
				unique case (cmd_q)
					CMD_ENTER: if (enter_ok) begin
						res_acc_q <= 1'b1;
						res_tok_q <= ts_q;
						level_q <= level_q + SPW'(1);
					end
					CMD_EXIT: if (exit_ok) begin
						res_acc_q <= 1'b1;
						level_q <= level_q - SPW'(1);
					end
					CMD_FRAME_BEG: if (enable_q) begin
						if (frame_open_q) level_q <= '0;
						frame_open_q <= 1'b1;
						fstart_q <= ts_q;
						for (int i = 0; i < 4; i++) fcnt_q[i] <= '0;
						res_acc_q <= 1'b1;
					end
					CMD_FRAME_END: if (fold_cnt_q != '0) begin
						res_acc_q <= 1'b1;
						res_fnum_q <= fclosed_q;
						res_rank_q <= rank_s2;
						res_val_q <= {32'd0, total_q};
					end
					CMD_UPLOAD: if (fe_ok) begin
						fcnt_q[0] <= fcnt_q[0] + 32'd1;
						fcnt_q[1] <= fcnt_q[1] + bytes_q;
						res_acc_q <= 1'b1;
					end
					CMD_OVERLAY: if (fe_ok) begin
						fcnt_q[2] <= fcnt_q[2] + 32'd1;
						if (first_q) fcnt_q[3] <= fcnt_q[3] + 32'd1;
						res_acc_q <= 1'b1;
					end
					CMD_READ_WORST: if (rd_valid) begin
						res_acc_q <= 1'b1;
						res_fnum_q <= rd_frame;
						res_rank_q <= idx_q;
						res_val_q <= {32'd0, rd_ticks};
					end
					CMD_READ_RUN: if (runok_s2) begin
						res_acc_q <= 1'b1;
						res_fnum_q <= fclosed_q;
						res_val_q <= runsel_s2;
					end
					default: ;
				endcase
			end
		end
	end

	// stack entries: section only is ever read
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && cmd_q == CMD_ENTER && enter_ok)
			stk_sec_q[level_q[SPI-1:0]] <= sec_q;
	end

	assign out_valid    = res_valid_q;
	assign accepted     = res_acc_q;
	assign token_out    = res_tok_q;
	assign frame_number = res_fnum_q;
	assign rank         = res_rank_q;
	assign read_value   = res_val_q;
endmodule

[sv/nsp_worst_cell.sv]
// One rank of the worst-frame table: compares, shifts from its upper neighbor, or takes the new frame.
module nsp_worst_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  nsp_pkg::wcell_ctl_t ctl,
	input  logic                up_valid,
	input  logic                up_takes,
	input  logic [31:0]         up_frame,
	input  logic [31:0]         up_ticks,
	output logic                valid,
	output logic                takes,
	output logic [31:0]         frame,
	output logic [31:0]         ticks
);
	import nsp_pkg::*;

	logic valid_q;
	logic [31:0] frame_q, ticks_q;

	// The new frame lands in the first cell that is empty or strictly faster.
	assign takes = up_takes | !valid_q | (ticks_q < ctl.ticks);
	assign valid = valid_q;
	assign frame = frame_q;
	assign ticks = ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert && takes) begin
			valid_q <= up_takes ? up_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && takes) begin
			if (up_takes) begin
				frame_q <= up_frame;
				ticks_q <= up_ticks;
			end else begin
				frame_q <= ctl.frame;
				ticks_q <= ctl.ticks;
			end
		end
	end
endmodule

[sv/nsp_fold_cell.sv]
// One section accumulator: frame ticks rotate around the ring, each run total folds its own section.
module nsp_fold_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        add,
	input  logic [31:0] add_value,
	input  logic        shift,
	input  logic        fold,
	input  logic [31:0] shift_in,
	output logic [31:0] frame_ticks,
	output logic [63:0] run_ticks
);
	import nsp_pkg::*;

	logic [31:0] frame_q;
	logic [63:0] run_q;

	assign frame_ticks = frame_q;
	assign run_ticks   = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			run_q   <= '0;
		end else if (shift) begin
			// fold own frame value on the first step only, then take neighbor's
			if (fold) run_q <= run_q + {32'd0, frame_q};
			frame_q <= shift_in;
		end else if (clear) begin
			frame_q <= '0;
		end else if (add) begin
			frame_q <= frame_q + add_value;
		end
	end
endmodule

[test/nsp_checker.sv]
// Result checker for the nested section profiler: predicts each result word and compares it.
`timescale 1ns / 1ps
module nsp_checker #(
	parameter int STACK_DEPTH   = 8,
	parameter int WORST_ENTRIES = 16,
	parameter int SECTION_COUNT = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] timestamp,
	input  logic [4:0]  section,
	input  logic [31:0] start_token,
	input  logic [31:0] byte_count,
	input  logic        first_draw,
	input  logic [4:0]  index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        accepted,
	input  logic [31:0] token_out,
	input  logic [31:0] frame_number,
	input  logic [4:0]  rank,
	input  logic [63:0] read_value,
	output int          errors,
	output int          pending,
	output int          results_seen
);
	import nsp_pkg::*;

	typedef struct packed {
		logic        acc;
		logic [31:0] tok;
		logic [31:0] fnum;
		logic [4:0]  rnk;
		logic [63:0] val;
	} answer_t;

	answer_t     answers_due[$];
	logic        prof_on;
	int unsigned depth;
	logic [4:0]  sec_stack[STACK_DEPTH];
	logic [31:0] frame_ticks[SECTION_COUNT];
	logic [31:0] frame_cnt[4];
	logic        open_frame;
	logic [31:0] open_time;
	logic [31:0] closed;
	logic [63:0] run_ticks[SECTION_COUNT];
	logic [63:0] run_sum[RUN_TOTAL_COUNT];
	logic [31:0] slow_frame[WORST_ENTRIES];
	logic [31:0] slow_ticks[WORST_ENTRIES];
	int unsigned slow_count;

	assign pending = answers_due.size();

	function automatic int unsigned place_frame(logic [31:0] fr, logic [31:0] tot);
		int unsigned pos;
		pos = 0;
		while (pos < slow_count && pos < WORST_ENTRIES && slow_ticks[pos] >= tot)
			pos++;
		if (pos >= WORST_ENTRIES)
			return WORST_ENTRIES;
		if (slow_count < WORST_ENTRIES)
			slow_count++;
		for (int k = int'(slow_count) - 1; k > int'(pos); k--) begin
			slow_frame[k] = slow_frame[k-1];
			slow_ticks[k] = slow_ticks[k-1];
		end
		slow_frame[pos] = fr;
		slow_ticks[pos] = tot;
		return pos;
	endfunction

	function automatic answer_t profile_event(cmd_t c, logic [31:0] ts, logic [4:0] sc,
			logic [31:0] tk, logic [31:0] by, logic fu, logic [4:0] ix);
		answer_t a;
		logic [31:0] tot;
		a = '0;
		case (c)
			CMD_ENTER: if (prof_on && depth < STACK_DEPTH && sc < SECTION_COUNT) begin
				sec_stack[depth] = sc;
				depth++;
				a.acc = 1'b1;
				a.tok = ts;
			end
			CMD_EXIT: if (prof_on && tk != 0 && sc < SECTION_COUNT && depth > 0
					&& sec_stack[depth-1] == sc) begin
				frame_ticks[sc] += ts - tk;
				depth--;
				a.acc = 1'b1;
			end
			CMD_FRAME_BEG: if (prof_on) begin
				if (open_frame)
					depth = 0;
				open_frame = 1'b1;
				open_time = ts;
				foreach (frame_ticks[s]) frame_ticks[s] = '0;
				foreach (frame_cnt[s]) frame_cnt[s] = '0;
				a.acc = 1'b1;
			end
			CMD_FRAME_END: if (prof_on && open_frame) begin
				tot = ts - open_time;
				open_frame = 1'b0;
				closed++;
				foreach (run_ticks[s]) run_ticks[s] += {32'd0, frame_ticks[s]};
				run_sum[0] += {32'd0, tot};
				for (int s = 0; s < 4; s++)
					run_sum[s+1] += {32'd0, frame_cnt[s]};
				a.acc = 1'b1;
				a.fnum = closed;
				a.rnk = 5'(place_frame(closed, tot));
				a.val = {32'd0, tot};
			end
			CMD_UPLOAD: if (prof_on && open_frame) begin
				frame_cnt[0]++;
				frame_cnt[1] += by;
				a.acc = 1'b1;
			end
			CMD_OVERLAY: if (prof_on && open_frame) begin
				frame_cnt[2]++;
				if (fu)
					frame_cnt[3]++;
				a.acc = 1'b1;
			end
			CMD_READ_WORST: if (ix < slow_count && ix < WORST_ENTRIES) begin
				a.acc = 1'b1;
				a.fnum = slow_frame[ix];
				a.rnk = ix;
				a.val = {32'd0, slow_ticks[ix]};
			end
			default: if (ix < SECTION_COUNT) begin
				a.acc = 1'b1;
				a.fnum = closed;
				a.val = run_ticks[ix];
			end else if (ix < SECTION_COUNT + RUN_TOTAL_COUNT) begin
				a.acc = 1'b1;
				a.fnum = closed;
				a.val = run_sum[ix - SECTION_COUNT];
			end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t a, got;
		if (!arst_n) begin
			answers_due.delete();
			errors <= 0;
			results_seen <= 0;
			prof_on = 1'b0;
			depth = 0;
			open_frame = 1'b0;
			open_time = '0;
			closed = '0;
			slow_count = 0;
			foreach (frame_ticks[s]) frame_ticks[s] = '0;
			foreach (frame_cnt[s]) frame_cnt[s] = '0;
			foreach (run_ticks[s]) run_ticks[s] = '0;
			foreach (run_sum[s]) run_sum[s] = '0;
		end else begin
			if (cfg_valid && cfg_ready)
				prof_on = cfg_data;
			if (in_valid && !in_stall)
				answers_due.push_back(profile_event(cmd_t'(command), timestamp, section,
					start_token, byte_count, first_draw, index));
			if (out_valid && !out_stall) begin
				got = {accepted, token_out, frame_number, rank, read_value};
				results_seen <= results_seen + 1;
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, got);
					errors <= errors + 1;
				end else begin
					a = answers_due.pop_front();
					if (got !== a) begin
						$display("%0t: mismatch expected acc=%0b tok=%h fn=%h rank=%0d val=%h",
							$time, a.acc, a.tok, a.fnum, a.rnk, a.val);
						$display("%0t:          actual   acc=%0b tok=%h fn=%h rank=%0d val=%h",
							$time, accepted, token_out, frame_number, rank, read_value);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

[test/tb_nested_section_profiler_topk.sv]
// Testbench top for the nested section profiler: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_nested_section_profiler_topk;
	import nsp_pkg::*;

	localparam int SECTIONS  = 19;
	localparam int DEPTH     = 8;
	localparam int DOG_LIMIT = 5000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0, cfg_data = 0, cfg_ready;
	logic        in_valid = 0, in_stall;
	logic [2:0]  command = '0;
	logic [31:0] timestamp = '0, start_token = '0, byte_count = '0;
	logic [4:0]  section = '0, index = '0;
	logic        first_draw = 0;
	logic        out_valid, out_stall = 0;
	logic        accepted;
	logic [31:0] token_out, frame_number;
	logic [4:0]  rank;
	logic [63:0] read_value;
	int          errors, pending, results_seen;
	int          idle_cycles = 0;
	int          stall_mode = 0;
	logic [31:0] clock_now = 32'h100;
	logic [31:0] tokens[$];
	logic [4:0]  open_secs[$];

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	nested_section_profiler_topk dut (.*);

	nsp_checker #(.STACK_DEPTH(DEPTH), .SECTION_COUNT(SECTIONS)) scoreboard (.*);

	// Receiver: switch among steady, light and heavy stall patterns.
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= DOG_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("nested_section_profiler_topk test failed");
			$finish;
		end
	end

	task automatic send_word(cmd_t c, logic [31:0] ts, logic [4:0] sc, logic [31:0] tk,
			logic [31:0] by, logic fu, logic [4:0] ix);
		command <= c;
		timestamp <= ts;
		section <= sc;
		start_token <= tk;
		byte_count <= by;
		first_draw <= fu;
		index <= ix;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// gap between bursts
		if ($urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_and_set(logic en);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= en;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	// Advance the time base and return the new value.
	task automatic tick(output logic [31:0] t);
		clock_now += $urandom_range(1, 2000);
		t = clock_now;
	endtask

	task automatic random_event();
		logic [31:0] t;
		int          pick;
		tick(t);
		pick = $urandom_range(0, 99);
		if (pick < 22 && open_secs.size() < DEPTH + 1) begin
			open_secs.push_back(5'($urandom_range(0, SECTIONS - 1)));
			tokens.push_back(t);
			send_word(CMD_ENTER, t, open_secs[$], $urandom, $urandom, 1'($urandom),
				5'($urandom));
		end else if (pick < 44 && open_secs.size() > 0) begin
			send_word(CMD_EXIT, t, open_secs[$], tokens[$] - $urandom_range(0, 1) * $urandom,
				$urandom, 1'($urandom), 5'($urandom));
			void'(open_secs.pop_back());
			void'(tokens.pop_back());
		end else if (pick < 52) begin
			open_secs.delete();
			tokens.delete();
			send_word(CMD_FRAME_BEG, t, 5'($urandom), $urandom, $urandom, 1'($urandom),
				5'($urandom));
		end else if (pick < 60) begin
			if ($urandom_range(0, 7) == 0) t = $urandom;
			send_word(CMD_FRAME_END, t, 5'($urandom), $urandom, $urandom, 1'($urandom),
				5'($urandom));
		end else if (pick < 68) begin
			send_word(CMD_UPLOAD, t, 5'($urandom), $urandom, $urandom, 1'($urandom),
				5'($urandom));
		end else if (pick < 76) begin
			send_word(CMD_OVERLAY, t, 5'($urandom), $urandom, $urandom, 1'($urandom),
				5'($urandom));
		end else if (pick < 84) begin
			send_word(CMD_READ_WORST, t, 5'($urandom), $urandom, $urandom, 1'($urandom),
				5'($urandom_range(0, 17)));
		end else if (pick < 94) begin
			send_word(CMD_READ_RUN, t, 5'($urandom), $urandom, $urandom, 1'($urandom),
				5'($urandom));
		end else begin
			// noise: any command, any field
			send_word(cmd_t'($urandom_range(0, 7)), $urandom, 5'($urandom), $urandom,
				$urandom, 1'($urandom), 5'($urandom));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// disabled: events refused, reads still answer
		send_word(CMD_FRAME_BEG, 32'h10, 0, 0, 0, 0, 0);
		send_word(CMD_READ_RUN, 0, 0, 0, 0, 0, 5'd23);
		send_word(CMD_READ_WORST, 0, 0, 0, 0, 0, 0);
		drain_and_set(1);
		send_word(CMD_UPLOAD, 32'h20, 0, 0, 32'hFFFF_FFFF, 0, 0);
		send_word(CMD_FRAME_BEG, 32'hFFFF_FF00, 0, 0, 0, 0, 0);
		send_word(CMD_ENTER, 32'h0, 5'd3, 0, 0, 0, 0);
		send_word(CMD_EXIT, 32'h50, 5'd3, 32'h0, 0, 0, 0);
		send_word(CMD_ENTER, 32'hFFFF_FFF0, 5'd18, 0, 0, 0, 0);
		send_word(CMD_ENTER, 32'h5, 5'd19, 0, 0, 0, 0);
		send_word(CMD_ENTER, 32'h6, 5'd31, 0, 0, 0, 0);
		send_word(CMD_EXIT, 32'h10, 5'd17, 32'hFFFF_FFF0, 0, 0, 0);
		send_word(CMD_EXIT, 32'h10, 5'd18, 32'hFFFF_FFF0, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			send_word(CMD_ENTER, 32'h20 + i, 5'(i), 0, 0, 0, 0);
		send_word(CMD_UPLOAD, 32'h40, 0, 0, 32'hFFFF_FFFF, 0, 0);
		send_word(CMD_OVERLAY, 32'h41, 0, 0, 0, 1, 0);
		send_word(CMD_OVERLAY, 32'h42, 0, 0, 0, 0, 0);
		send_word(CMD_FRAME_BEG, 32'h50, 0, 0, 0, 0, 0);
		send_word(CMD_FRAME_END, 32'h40, 0, 0, 0, 0, 0);
		send_word(CMD_FRAME_END, 32'h41, 0, 0, 0, 0, 0);
		send_word(CMD_READ_WORST, 0, 0, 0, 0, 0, 5'd0);
		send_word(CMD_READ_WORST, 0, 0, 0, 0, 0, 5'd1);
		send_word(CMD_READ_RUN, 0, 0, 0, 0, 0, 5'd31);
		for (int phase = 0; phase < 5; phase++) begin
			drain_and_set(phase != 2);
			open_secs.delete();
			tokens.delete();
			repeat (140) random_event();
		end
		// final sweep: read_worst at even and read_run at odd indices from 0 to 31
		for (int i = 0; i < 32; i++)
			send_word(i[0] ? CMD_READ_RUN : CMD_READ_WORST, 0, 0, 0, 0, 0, 5'(i));
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d result words over five enable phases with frames, nesting,",
			results_seen);
		$display("worst-table ranking, run-total reads and refused events");
		if (errors == 0)
			$display("nested_section_profiler_topk test passed");
		else
			$display("nested_section_profiler_topk test failed");
		$finish;
	end
endmodule

[files.f]
sv/nsp_pkg.sv
sv/nsp_worst_cell.sv
sv/nsp_fold_cell.sv
sv/nested_section_profiler_topk.sv
test/nsp_checker.sv
test/tb_nested_section_profiler_topk.sv
